/* hdl/gbmas_pkg.sv */
// Shared types and constants for the GBM antithetic path stepper.
// Holds controller states, datapath opcodes, command/status structs and the reciprocal table.
// No dependencies.
package gbmas_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int QUOT_W     = 9;
  localparam int SQRT_STEPS = 32;
  localparam int EXP_TERMS  = 12;

  localparam logic [27:0] LN2_Q28   = 28'd186065280;
  localparam logic [28:0] ONE_Q28   = 29'h1000_0000;
  // floor(2^40 / LN2_Q28)
  localparam logic [12:0] LN2_RECIP = 13'd5909;

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PRICE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISK_FREE_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDEND_YIELD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLATILITY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DT        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_PATH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANTITHETIC_ON  = 3'd6;

  typedef enum logic [4:0] {
    S_IDLE, S_VSQ, S_DA, S_DM, S_DRIFT, S_SQRT, S_DIFF, S_SHOCK, S_X,
    S_DIV, S_QREM, S_QFIX, S_RED, S_TMUL, S_TREC, S_TCORR, S_LVL, S_SCALE, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    T_NOP, T_VSQ, T_DA, T_DM, T_DRIFT, T_SQRT, T_DIFF, T_SHOCK
  } t_op_t;

  typedef enum logic [3:0] {
    L_NOP, L_LOAD, L_X, L_DIV, L_QREM, L_QFIX, L_RED, L_TMUL, L_TREC, L_TCORR, L_LVL,
    L_SCALE
  } l_op_t;

  typedef struct packed {
    logic        ready;
    t_op_t       t_op;
    l_op_t       l_op;
    logic [3:0]  k;
    logic        load_out;
    logic [15:0] out_idx;
    logic        out_done;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic out_busy;
  } stat_t;

  // floor(2^32 / k) for the Taylor term divisors
  function automatic logic [32:0] recip(input logic [3:0] k);
    logic [32:0] v;
    case (k)
      4'd1:    v = 33'h1_0000_0000;
      4'd2:    v = 33'd2147483648;
      4'd3:    v = 33'd1431655765;
      4'd4:    v = 33'd1073741824;
      4'd5:    v = 33'd858993459;
      4'd6:    v = 33'd715827882;
      4'd7:    v = 33'd613566756;
      4'd8:    v = 33'd536870912;
      4'd9:    v = 33'd477218588;
      4'd10:   v = 33'd429496729;
      4'd11:   v = 33'd390451572;
      4'd12:   v = 33'd357913941;
      default: v = 33'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/gbmas_terms.sv */
// Per-path terms: drift, diffusion (bit-serial square root) and per-step shock.
// Driven by gbmas_ctrl commands; uses gbmas_pkg.
module gbmas_terms (
  input  logic                clk,
  input  gbmas_pkg::cmd_t     cmd,
  input  logic [31:0]         risk_free_rate,
  input  logic [31:0]         dividend_yield,
  input  logic [31:0]         volatility,
  input  logic [31:0]         step_dt,
  input  logic signed [15:0]  eps,
  output logic signed [31:0]  drift,
  output logic signed [36:0]  shock
);

  logic [63:0]        vsq;
  logic               neg;
  logic [35:0]        mag;
  logic [51:0]        ph;
  logic [51:0]        plo;
  logic [31:0]        diffusion;
  logic [63:0]        rad;
  logic [31:0]        root;
  logic [35:0]        srem;

  logic signed [36:0] a;
  logic [52:0]        psum;
  logic [36:0]        prod;
  logic [31:0]        drift_next;
  logic [35:0]        sq_sh;
  logic [35:0]        sq_t;
  logic signed [48:0] sprod;
  logic signed [48:0] sadj;
  logic [63:0]        dprod;

  assign a = {{5{risk_free_rate[31]}}, risk_free_rate}
           - {{5{dividend_yield[31]}}, dividend_yield}
           - {2'b0, vsq[63:29]};

  assign psum = {1'b0, ph} + {17'b0, plo[51:16]};
  assign prod = psum[52:16];

  always_comb begin
    if (neg) begin
      if (prod > 37'd2147483648) drift_next = 32'h8000_0000;
      else drift_next = 32'(37'd0 - prod);
    end else begin
      if (prod > 37'd2147483647) drift_next = 32'h7FFF_FFFF;
      else drift_next = prod[31:0];
    end
  end

  assign sq_sh = {srem[33:0], rad[63:62]};
  assign sq_t  = {2'b0, root, 2'b01};

  // truncate toward zero on the divide by 4096
  assign sprod = $signed({1'b0, diffusion}) * eps;
  assign sadj  = sprod[48] ? sprod + 49'sd4095 : sprod;
  assign dprod = volatility * root;

  always_ff @(posedge clk) begin
    case (cmd.t_op)
      gbmas_pkg::T_VSQ: begin
        vsq  <= volatility * volatility;
        rad  <= {step_dt, 32'b0};
        root <= '0;
        srem <= '0;
      end
      gbmas_pkg::T_DA: begin
        neg <= a[36];
        mag <= a[36] ? 36'(-a) : 36'(a);
      end
      gbmas_pkg::T_DM: begin
        ph  <= mag * step_dt[31:16];
        plo <= mag * step_dt[15:0];
      end
      gbmas_pkg::T_DRIFT: drift <= drift_next;
      gbmas_pkg::T_SQRT: begin
        rad <= {rad[61:0], 2'b00};
        if (sq_sh >= sq_t) begin
          srem <= sq_sh - sq_t;
          root <= {root[30:0], 1'b1};
        end else begin
          srem <= sq_sh;
          root <= {root[30:0], 1'b0};
        end
      end
      gbmas_pkg::T_DIFF:  diffusion <= dprod[63:32];
      gbmas_pkg::T_SHOCK: shock <= sadj[48:12];
      default: ;
    endcase
  end

endmodule

/* hdl/gbmas_lane.sv */
// One price lane: range reduction by ln2, Taylor exponential and saturating rescale.
// Driven by gbmas_ctrl commands; uses gbmas_pkg.
module gbmas_lane (
  input  logic               clk,
  input  gbmas_pkg::cmd_t    cmd,
  input  logic               negate,
  input  logic [31:0]        init_price,
  input  logic signed [31:0] drift,
  input  logic signed [36:0] shock,
  output logic [31:0]        level
);

  logic                      xneg;
  logic [37:0]               rem;
  logic [gbmas_pkg::QUOT_W-1:0] q;
  logic signed [10:0]        n;
  logic [27:0]               r;
  logic [28:0]               term;
  logic [28:0]               t;
  logic [28:0]               q0;
  logic [29:0]               sum;
  logic [33:0]               pl;

  logic signed [37:0]        x;
  logic signed [37:0]        sh;
  logic                      nz;
  logic [10:0]               qe;
  logic [40:0]               qprod;
  logic [36:0]               qln;
  logic [56:0]               mprod;
  logic [61:0]               rprod;
  logic [32:0]               qk;
  logic [32:0]               rmd;
  logic [28:0]               tn;
  logic [61:0]               lp;
  logic [10:0]               mn;
  logic [65:0]               wide;
  logic [31:0]               scaled;

  assign sh = {shock[36], shock};
  assign x  = negate ? {{6{drift[31]}}, drift} - sh : {{6{drift[31]}}, drift} + sh;
  assign nz = rem != '0;
  assign qe = 11'(q);

  // |x| stays below 2^36; the reciprocal estimate of |x| / ln2 is low by at most one
  assign qprod = rem[35:8] * gbmas_pkg::LN2_RECIP;
  assign qln   = q * gbmas_pkg::LN2_Q28;

  assign mprod = term * r;
  assign rprod = t * gbmas_pkg::recip(cmd.k);
  assign qk    = q0 * cmd.k;
  assign rmd   = {4'b0, t} - qk;
  assign tn    = (rmd >= 33'(cmd.k)) ? q0 + 29'd1 : q0;
  assign lp    = level * sum;

  assign mn   = 11'(-n);
  assign wide = {32'b0, pl} << n[4:0];

  always_comb begin
    if (!n[10]) begin
      if (n[9:5] != '0) scaled = (pl != '0) ? 32'hFFFF_FFFF : 32'd0;
      else if (wide[65:32] != '0) scaled = 32'hFFFF_FFFF;
      else scaled = wide[31:0];
    end else begin
      if (mn >= 11'd63) scaled = 32'd0;
      else scaled = 32'(pl >> mn[5:0]);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.l_op)
      gbmas_pkg::L_LOAD: level <= init_price;
      gbmas_pkg::L_X: begin
        xneg <= x[37];
        rem  <= x[37] ? 38'(-x) : 38'(x);
        q    <= '0;
      end
      gbmas_pkg::L_DIV:  q <= qprod[40:32];
      gbmas_pkg::L_QREM: rem <= rem - {1'b0, qln};
      gbmas_pkg::L_QFIX: begin
        // add back the one the estimate may have dropped
        if (rem >= {10'b0, gbmas_pkg::LN2_Q28}) begin
          rem <= rem - {10'b0, gbmas_pkg::LN2_Q28};
          q   <= q + 1'b1;
        end
      end
      gbmas_pkg::L_RED: begin
        // floor division: a negative exponent with a remainder steps one more down
        if (xneg) begin
          n <= $signed(11'd0 - qe - 11'(nz));
          r <= nz ? gbmas_pkg::LN2_Q28 - rem[27:0] : 28'd0;
        end else begin
          n <= $signed(qe);
          r <= rem[27:0];
        end
        term <= gbmas_pkg::ONE_Q28;
        sum  <= {1'b0, gbmas_pkg::ONE_Q28};
      end
      gbmas_pkg::L_TMUL: t <= mprod[56:28];
      gbmas_pkg::L_TREC: q0 <= rprod[60:32];
      gbmas_pkg::L_TCORR: begin
        term <= tn;
        sum  <= sum + {1'b0, tn};
      end
      gbmas_pkg::L_LVL:   pl <= lp[61:28];
      gbmas_pkg::L_SCALE: level <= scaled;
      default: ;
    endcase
  end

endmodule

/* hdl/gbmas_ctrl.sv */
// Sequencer for the path stepper: issues term, lane and output commands, keeps the step count.
// Uses gbmas_pkg.
module gbmas_ctrl #(
  parameter int STEP_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  gbmas_pkg::stat_t   st,
  input  logic [15:0]        steps_per_path,
  output gbmas_pkg::cmd_t    cmd
);

  localparam int CW = (STEP_WIDTH > 16) ? STEP_WIDTH : 16;

  gbmas_pkg::state_t     state, state_next;
  logic [4:0]            cnt, cnt_next;
  logic [STEP_WIDTH-1:0] step_count, step_count_next;

  logic [STEP_WIDTH-1:0] idx;
  logic [15:0]           spp_eff;
  logic                  done;

  assign idx     = step_count + 1'b1;
  assign spp_eff = (steps_per_path == 16'd0) ? 16'd1 : steps_per_path;
  assign done    = (CW'(idx) >= CW'(spp_eff)) || (idx == '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gbmas_pkg::S_IDLE;
      cnt        <= '0;
      step_count <= '0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      step_count <= step_count_next;
    end
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    step_count_next = step_count;
    cmd             = '0;
    cmd.t_op        = gbmas_pkg::T_NOP;
    cmd.l_op        = gbmas_pkg::L_NOP;
    cmd.k           = cnt[3:0];
    cmd.out_idx     = 16'(CW'(idx));
    cmd.out_done    = done;
    case (state)
      gbmas_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        if (st.in_fire) begin
          state_next = (step_count == '0) ? gbmas_pkg::S_VSQ : gbmas_pkg::S_SHOCK;
        end
      end
      gbmas_pkg::S_VSQ: begin
        cmd.t_op   = gbmas_pkg::T_VSQ;
        cmd.l_op   = gbmas_pkg::L_LOAD;
        state_next = gbmas_pkg::S_DA;
      end
      gbmas_pkg::S_DA: begin
        cmd.t_op   = gbmas_pkg::T_DA;
        state_next = gbmas_pkg::S_DM;
      end
      gbmas_pkg::S_DM: begin
        cmd.t_op   = gbmas_pkg::T_DM;
        state_next = gbmas_pkg::S_DRIFT;
      end
      gbmas_pkg::S_DRIFT: begin
        cmd.t_op   = gbmas_pkg::T_DRIFT;
        cnt_next   = '0;
        state_next = gbmas_pkg::S_SQRT;
      end
      gbmas_pkg::S_SQRT: begin
        cmd.t_op = gbmas_pkg::T_SQRT;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(gbmas_pkg::SQRT_STEPS - 1)) state_next = gbmas_pkg::S_DIFF;
      end
      gbmas_pkg::S_DIFF: begin
        cmd.t_op   = gbmas_pkg::T_DIFF;
        state_next = gbmas_pkg::S_SHOCK;
      end
      gbmas_pkg::S_SHOCK: begin
        cmd.t_op   = gbmas_pkg::T_SHOCK;
        state_next = gbmas_pkg::S_X;
      end
      gbmas_pkg::S_X: begin
        cmd.l_op   = gbmas_pkg::L_X;
        cnt_next   = '0;
        state_next = gbmas_pkg::S_DIV;
      end
      gbmas_pkg::S_DIV: begin
        cmd.l_op   = gbmas_pkg::L_DIV;
        state_next = gbmas_pkg::S_QREM;
      end
      gbmas_pkg::S_QREM: begin
        cmd.l_op   = gbmas_pkg::L_QREM;
        state_next = gbmas_pkg::S_QFIX;
      end
      gbmas_pkg::S_QFIX: begin
        cmd.l_op   = gbmas_pkg::L_QFIX;
        state_next = gbmas_pkg::S_RED;
      end
      gbmas_pkg::S_RED: begin
        cmd.l_op   = gbmas_pkg::L_RED;
        cnt_next   = 5'd1;
        state_next = gbmas_pkg::S_TMUL;
      end
      gbmas_pkg::S_TMUL: begin
        cmd.l_op   = gbmas_pkg::L_TMUL;
        state_next = gbmas_pkg::S_TREC;
      end
      gbmas_pkg::S_TREC: begin
        cmd.l_op   = gbmas_pkg::L_TREC;
        state_next = gbmas_pkg::S_TCORR;
      end
      gbmas_pkg::S_TCORR: begin
        cmd.l_op = gbmas_pkg::L_TCORR;
        if (cnt == 5'(gbmas_pkg::EXP_TERMS)) begin
          state_next = gbmas_pkg::S_LVL;
        end else begin
          cnt_next   = cnt + 5'd1;
          state_next = gbmas_pkg::S_TMUL;
        end
      end
      gbmas_pkg::S_LVL: begin
        cmd.l_op   = gbmas_pkg::L_LVL;
        state_next = gbmas_pkg::S_SCALE;
      end
      gbmas_pkg::S_SCALE: begin
        cmd.l_op   = gbmas_pkg::L_SCALE;
        state_next = gbmas_pkg::S_FIN;
      end
      gbmas_pkg::S_FIN: begin
        // hold the result until the output register frees up
        if (!st.out_busy) begin
          cmd.load_out    = 1'b1;
          step_count_next = done ? '0 : idx;
          state_next      = gbmas_pkg::S_IDLE;
        end
      end
      default: state_next = gbmas_pkg::S_IDLE;
    endcase
  end

  a_no_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !st.out_busy) else $error("output overwritten while stalled");

  a_done_clears_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && done) |=> step_count == '0) else $error("path end did not clear count");

  a_terms_at_start: assert property (@(posedge clk) disable iff (rst)
    (state == gbmas_pkg::S_VSQ) |-> step_count == '0) else $error("terms recomputed mid path");

  a_term_range: assert property (@(posedge clk) disable iff (rst)
    (state == gbmas_pkg::S_TCORR) |-> (cnt >= 5'd1 && cnt <= 5'(gbmas_pkg::EXP_TERMS)))
    else $error("Taylor index out of range");

endmodule

/* hdl/gbm_antithetic_path_step_top.sv */
// Each accepted sample runs the ln2 range reduction and the 12-term Taylor loop; at a path start
// the step first recomputes drift and diffusion (bit-serial square root). A new sample is accepted
// only in the idle state, once the previous result has been loaded into the output register.
// A stalled result holds the next result in its final state only.
// Reset (rst, synchronous): configuration registers to their defaults, step count zero, output empty.
module gbm_antithetic_path_step_top #(
  parameter int STEP_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gbmas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [15:0]               normal_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      primary_price,
  output logic [31:0]                      mirror_price,
  output logic [15:0]                      step_index,
  output logic                             path_done
);

  logic [31:0]        initial_price;
  logic [31:0]        risk_free_rate;
  logic [31:0]        dividend_yield;
  logic [31:0]        volatility;
  logic [31:0]        step_dt;
  logic [15:0]        steps_per_path;
  logic               antithetic_on;
  logic signed [15:0] eps;

  gbmas_pkg::cmd_t    cmd;
  gbmas_pkg::stat_t   st;
  logic signed [31:0] drift;
  logic signed [36:0] shock;
  logic [31:0]        p_level;
  logic [31:0]        m_level;

  assign cfg_ready   = 1'b1;
  assign in_stall    = !cmd.ready;
  assign st.in_fire  = in_valid && cmd.ready;
  assign st.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_price  <= 32'd6553600;
      risk_free_rate <= '0;
      dividend_yield <= '0;
      volatility     <= '0;
      step_dt        <= '0;
      steps_per_path <= 16'd1;
      antithetic_on  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        gbmas_pkg::REG_INITIAL_PRICE:  initial_price  <= cfg_data;
        gbmas_pkg::REG_RISK_FREE_RATE: risk_free_rate <= cfg_data;
        gbmas_pkg::REG_DIVIDEND_YIELD: dividend_yield <= cfg_data;
        gbmas_pkg::REG_VOLATILITY:     volatility     <= cfg_data;
        gbmas_pkg::REG_STEP_DT:        step_dt        <= cfg_data;
        gbmas_pkg::REG_STEPS_PER_PATH: steps_per_path <= cfg_data[15:0];
        gbmas_pkg::REG_ANTITHETIC_ON:  antithetic_on  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st.in_fire) eps <= normal_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      primary_price <= p_level;
      mirror_price  <= antithetic_on ? m_level : 32'd0;
      step_index    <= cmd.out_idx;
      path_done     <= cmd.out_done;
    end
  end

  gbmas_ctrl #(.STEP_WIDTH(STEP_WIDTH)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .st             (st),
    .steps_per_path (steps_per_path),
    .cmd            (cmd)
  );

  gbmas_terms u_terms (
    .clk            (clk),
    .cmd            (cmd),
    .risk_free_rate (risk_free_rate),
    .dividend_yield (dividend_yield),
    .volatility     (volatility),
    .step_dt        (step_dt),
    .eps            (eps),
    .drift          (drift),
    .shock          (shock)
  );

  gbmas_lane u_primary (
    .clk        (clk),
    .cmd        (cmd),
    .negate     (1'b0),
    .init_price (initial_price),
    .drift      (drift),
    .shock      (shock),
    .level      (p_level)
  );

  gbmas_lane u_mirror (
    .clk        (clk),
    .cmd        (cmd),
    .negate     (1'b1),
    .init_price (initial_price),
    .drift      (drift),
    .shock      (shock),
    .level      (m_level)
  );

endmodule
